[rtl/tsse_pkg.sv]
// tsse_pkg: shared types, widths and register codes of the truncated sampson error block
// no dependencies; used by every module under rtl by scoped names
package tsse_pkg;

    localparam int COORD_WIDTH = 32;      // saturation width of input coordinates
    localparam int DATA_W      = 32;      // port width of one coordinate and of the residual
    localparam int POSE_W      = 31;      // Q1.30 pose components
    localparam int ENT_W       = 32;      // essential matrix entries, Q24
    localparam int ROT_W       = 34;      // rotation entries, Q30
    localparam int NUM_REGS    = 8;
    localparam int ADDR_W      = 5;
    localparam int LO_EXP      = 27;      // normalized maximum lies in [2^27, 2^28)
    localparam int SAT_EXP     = 45;      // scaled third entry limit
    localparam int SQ_W        = 59;      // scaled sum of squares
    localparam int SQRT_STEPS  = 30;      // root bits of a SQ_W-bit radicand
    localparam int ROOT_W      = 30;
    localparam int DIV_STEPS   = 64 - LO_EXP;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;
    localparam int SETTLE_CYCLES = 6;     // pose pipeline refresh after a register write
    localparam int SETTLE_W    = 3;

    localparam int USER_TRUNC = 0;
    localparam int USER_DEGEN = 1;

    localparam logic signed [POSE_W-1:0] POSE_ONE_RESET = 31'sh3FFF_FFFF;
    localparam logic signed [DATA_W-1:0] CLAMP_RESET    = -32'sd65536;
    localparam logic signed [DATA_W-1:0] RES_MAX        = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] RES_MIN        = 32'sh8000_0000;

    typedef enum logic [2:0] {
        REG_ROT_QX,
        REG_ROT_QY,
        REG_ROT_QZ,
        REG_ROT_QW,
        REG_TRANS_X,
        REG_TRANS_Y,
        REG_TRANS_Z,
        REG_CLAMP_LEVEL
    } tsse_reg_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] first_x;
        logic signed [DATA_W-1:0] first_y;
        logic signed [DATA_W-1:0] second_x;
        logic signed [DATA_W-1:0] second_y;
    } tsse_item_t;

    typedef struct packed {
        logic signed [POSE_W-1:0] qx;
        logic signed [POSE_W-1:0] qy;
        logic signed [POSE_W-1:0] qz;
        logic signed [POSE_W-1:0] qw;
        logic signed [POSE_W-1:0] tx;
        logic signed [POSE_W-1:0] ty;
        logic signed [POSE_W-1:0] tz;
    } tsse_pose_t;

    // entry (i,j) of E at index 3*i+j
    typedef logic [8:0][ENT_W-1:0] tsse_emat_t;

    typedef struct packed {
        logic degen;
        logic sat;
        logic v2pos;
        logic neg;
    } tsse_flags_t;

    function automatic logic signed [DATA_W-1:0] coord_sat(input logic signed [DATA_W-1:0] v);
        logic signed [63:0] wide;
        logic signed [63:0] lim;
        begin
            wide = 64'(v);
            lim  = 64'sd1 <<< (COORD_WIDTH - 1);
            if (COORD_WIDTH < DATA_W) begin
                if (wide >= lim) begin
                    wide = lim - 64'sd1;
                end
                if (wide < -lim) begin
                    wide = -lim;
                end
            end
            return DATA_W'(wide);
        end
    endfunction

endpackage

[rtl/truncated_sampson_error.sv]
// truncated_sampson_error: top level with the register port, pose pipeline, queue and datapath
// depends on tsse_pkg, tsse_front, tsse_fifo, tsse_pose, tsse_core
//
// Scores one point correspondence per clock against the configured pose and returns the
// signed Sampson residual in Q16.16, truncated to clamp_level when that is nonnegative.
// One transaction is accepted every cycle while s_tready is high; a result passes the input
// register, one queue slot and 77 datapath stages (seven for the epipolar terms and scaling,
// 31 for the bit-serial square root, 38 for the restoring divider and one output register).
// A stalled result stops the datapath; the four-entry queue then fills and s_tready falls.
// After each register write s_tready stays low while the four-stage rotation and essential
// matrix pipeline takes up the new pose.
module truncated_sampson_error (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [127:0] s_tdata,   // first_x, first_y, second_x, second_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // residual
    output logic [1:0]  m_tuser,    // truncated, degenerate
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic signed [30:0]            qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [30:0]            tx_reg, ty_reg, tz_reg;
    logic signed [31:0]            clamp_level_reg;
    logic [tsse_pkg::SETTLE_W-1:0] hold_reg, hold_next;
    tsse_pkg::tsse_reg_t           idx;
    logic                          wr_en;
    tsse_pkg::tsse_pose_t          pose;
    tsse_pkg::tsse_emat_t          emat;
    tsse_pkg::tsse_item_t          front_item, fifo_head;
    logic                          push, pop, fifo_full, fifo_empty;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = tsse_pkg::tsse_reg_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qx_reg          <= '0;
            qy_reg          <= '0;
            qz_reg          <= '0;
            qw_reg          <= tsse_pkg::POSE_ONE_RESET;
            tx_reg          <= '0;
            ty_reg          <= '0;
            tz_reg          <= tsse_pkg::POSE_ONE_RESET;
            clamp_level_reg <= tsse_pkg::CLAMP_RESET;
        end else if (wr_en) begin
            unique case (idx)
                tsse_pkg::REG_ROT_QX:      qx_reg          <= pwdata[30:0];
                tsse_pkg::REG_ROT_QY:      qy_reg          <= pwdata[30:0];
                tsse_pkg::REG_ROT_QZ:      qz_reg          <= pwdata[30:0];
                tsse_pkg::REG_ROT_QW:      qw_reg          <= pwdata[30:0];
                tsse_pkg::REG_TRANS_X:     tx_reg          <= pwdata[30:0];
                tsse_pkg::REG_TRANS_Y:     ty_reg          <= pwdata[30:0];
                tsse_pkg::REG_TRANS_Z:     tz_reg          <= pwdata[30:0];
                tsse_pkg::REG_CLAMP_LEVEL: clamp_level_reg <= pwdata;
                default:                   clamp_level_reg <= clamp_level_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            tsse_pkg::REG_ROT_QX:      prdata = 32'(qx_reg);
            tsse_pkg::REG_ROT_QY:      prdata = 32'(qy_reg);
            tsse_pkg::REG_ROT_QZ:      prdata = 32'(qz_reg);
            tsse_pkg::REG_ROT_QW:      prdata = 32'(qw_reg);
            tsse_pkg::REG_TRANS_X:     prdata = 32'(tx_reg);
            tsse_pkg::REG_TRANS_Y:     prdata = 32'(ty_reg);
            tsse_pkg::REG_TRANS_Z:     prdata = 32'(tz_reg);
            tsse_pkg::REG_CLAMP_LEVEL: prdata = clamp_level_reg;
            default:                   prdata = '0;
        endcase
    end

    // hold off new items until E reflects the new pose
    always_comb begin
        hold_next = hold_reg;
        if (wr_en) begin
            hold_next = tsse_pkg::SETTLE_W'(tsse_pkg::SETTLE_CYCLES);
        end else if (hold_reg != '0) begin
            hold_next = hold_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= tsse_pkg::SETTLE_W'(tsse_pkg::SETTLE_CYCLES);
        end else begin
            hold_reg <= hold_next;
        end
    end

    assign pose.qx = qx_reg;
    assign pose.qy = qy_reg;
    assign pose.qz = qz_reg;
    assign pose.qw = qw_reg;
    assign pose.tx = tx_reg;
    assign pose.ty = ty_reg;
    assign pose.tz = tz_reg;

    tsse_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .hold      (hold_reg != '0),
        .fifo_full (fifo_full),
        .push      (push),
        .item      (front_item)
    );

    tsse_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (front_item),
        .full      (fifo_full),
        .pop       (pop),
        .empty     (fifo_empty),
        .head      (fifo_head)
    );

    tsse_pose u_pose (
        .aclk (aclk),
        .pose (pose),
        .emat (emat)
    );

    tsse_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fifo_empty  (fifo_empty),
        .head        (fifo_head),
        .pop         (pop),
        .emat        (emat),
        .clamp_level (clamp_level_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[tsse_pkg::USER_DEGEN]) |->
        (m_tdata == 32'd0 && !m_tuser[tsse_pkg::USER_TRUNC]))
        else $error("degenerate result with nonzero residual or truncation");

    a_trunc_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[tsse_pkg::USER_TRUNC]) |->
        (m_tdata == clamp_level_reg && !clamp_level_reg[31]))
        else $error("truncated result differs from a nonnegative clamp level");

    a_write_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> !s_tready)
        else $error("input accepted while the pose pipeline settles");

endmodule

[rtl/tsse_front.sv]
// tsse_front: input stage, takes stream transactions and saturates the coordinates
// depends on tsse_pkg; feeds tsse_fifo
module tsse_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [127:0]         s_tdata,
    input  logic                 hold,
    input  logic                 fifo_full,
    output logic                 push,
    output tsse_pkg::tsse_item_t item
);

    logic                 fv_reg, fv_next;
    tsse_pkg::tsse_item_t item_reg;
    logic                 accept;

    assign s_tready = (!fv_reg || !fifo_full) && !hold;
    assign accept   = s_tvalid && s_tready;
    assign push     = fv_reg && !fifo_full;
    assign item     = item_reg;

    always_comb begin
        fv_next = fv_reg;
        if (accept) begin
            fv_next = 1'b1;
        end else if (push) begin
            fv_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else begin
            fv_reg <= fv_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.first_x  <= tsse_pkg::coord_sat(s_tdata[31:0]);
            item_reg.first_y  <= tsse_pkg::coord_sat(s_tdata[63:32]);
            item_reg.second_x <= tsse_pkg::coord_sat(s_tdata[95:64]);
            item_reg.second_y <= tsse_pkg::coord_sat(s_tdata[127:96]);
        end
    end

endmodule

[rtl/tsse_fifo.sv]
// tsse_fifo: short queue of correspondences between the input stage and the datapath
// depends on tsse_pkg
module tsse_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  tsse_pkg::tsse_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 empty,
    output tsse_pkg::tsse_item_t head
);

    tsse_pkg::tsse_item_t                mem_reg [tsse_pkg::FIFO_DEPTH];
    logic [tsse_pkg::FIFO_AW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [tsse_pkg::FIFO_AW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [tsse_pkg::FIFO_AW:0]          count_reg, count_next;

    assign full  = count_reg == (tsse_pkg::FIFO_AW+1)'(tsse_pkg::FIFO_DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/tsse_pose.sv]
// tsse_pose: builds R(q) and E = [t]x R from the pose registers in four register stages
// depends on tsse_pkg
module tsse_pose (
    input  logic                 aclk,
    input  tsse_pkg::tsse_pose_t pose,
    output tsse_pkg::tsse_emat_t emat
);

    localparam logic signed [tsse_pkg::ROT_W-1:0] ONE30 = 34'sd1073741824;

    logic signed [61:0]                 pq_reg  [9];   // xx yy zz xy zw xz yw yz xw
    logic signed [tsse_pkg::ROT_W-1:0]  rot_reg [9];
    logic signed [63:0]                 tr_reg  [18];
    tsse_pkg::tsse_emat_t               emat_reg;

    function automatic logic signed [tsse_pkg::ROT_W-1:0] rnd29(input logic signed [63:0] v);
        logic signed [63:0] t;
        begin
            t = (v + (64'sd1 <<< 28)) >>> 29;
            return tsse_pkg::ROT_W'(t);
        end
    endfunction

    // round half up of (a - b) / 2^36
    function automatic logic [tsse_pkg::ENT_W-1:0] rdiff36(input logic signed [63:0] a,
                                                          input logic signed [63:0] b);
        logic signed [65:0] d;
        begin
            d = 66'(a) - 66'(b) + (66'sd1 <<< 35);
            d = d >>> 36;
            return tsse_pkg::ENT_W'(d);
        end
    endfunction

    always_ff @(posedge aclk) begin
        pq_reg[0] <= pose.qx * pose.qx;
        pq_reg[1] <= pose.qy * pose.qy;
        pq_reg[2] <= pose.qz * pose.qz;
        pq_reg[3] <= pose.qx * pose.qy;
        pq_reg[4] <= pose.qz * pose.qw;
        pq_reg[5] <= pose.qx * pose.qz;
        pq_reg[6] <= pose.qy * pose.qw;
        pq_reg[7] <= pose.qy * pose.qz;
        pq_reg[8] <= pose.qx * pose.qw;
    end

    always_ff @(posedge aclk) begin
        rot_reg[0] <= ONE30 - rnd29(64'(pq_reg[1]) + 64'(pq_reg[2]));
        rot_reg[1] <= rnd29(64'(pq_reg[3]) - 64'(pq_reg[4]));
        rot_reg[2] <= rnd29(64'(pq_reg[5]) + 64'(pq_reg[6]));
        rot_reg[3] <= rnd29(64'(pq_reg[3]) + 64'(pq_reg[4]));
        rot_reg[4] <= ONE30 - rnd29(64'(pq_reg[0]) + 64'(pq_reg[2]));
        rot_reg[5] <= rnd29(64'(pq_reg[7]) - 64'(pq_reg[8]));
        rot_reg[6] <= rnd29(64'(pq_reg[5]) - 64'(pq_reg[6]));
        rot_reg[7] <= rnd29(64'(pq_reg[7]) + 64'(pq_reg[8]));
        rot_reg[8] <= ONE30 - rnd29(64'(pq_reg[0]) + 64'(pq_reg[1]));
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < 3; j++) begin
            tr_reg[6*j]   <= pose.ty * rot_reg[6+j];
            tr_reg[6*j+1] <= pose.tz * rot_reg[3+j];
            tr_reg[6*j+2] <= pose.tz * rot_reg[j];
            tr_reg[6*j+3] <= pose.tx * rot_reg[6+j];
            tr_reg[6*j+4] <= pose.tx * rot_reg[3+j];
            tr_reg[6*j+5] <= pose.ty * rot_reg[j];
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < 3; j++) begin
            emat_reg[j]   <= rdiff36(tr_reg[6*j],   tr_reg[6*j+1]);
            emat_reg[3+j] <= rdiff36(tr_reg[6*j+2], tr_reg[6*j+3]);
            emat_reg[6+j] <= rdiff36(tr_reg[6*j+4], tr_reg[6*j+5]);
        end
    end

    assign emat = emat_reg;

endmodule

[rtl/tsse_core.sv]
// tsse_core: scoring pipeline, epipolar terms, normalization, root and division stages
// depends on tsse_pkg; takes items from tsse_fifo and E from tsse_pose
module tsse_core (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     fifo_empty,
    input  tsse_pkg::tsse_item_t     head,
    output logic                     pop,
    input  tsse_pkg::tsse_emat_t     emat,
    input  logic signed [31:0]       clamp_level,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [31:0]              m_tdata,
    output logic [1:0]               m_tuser
);

    localparam int SQS  = tsse_pkg::SQRT_STEPS;
    localparam int DVS  = tsse_pkg::DIV_STEPS;
    localparam int SQW  = tsse_pkg::SQ_W;
    localparam int SRW  = tsse_pkg::SQ_W + 1;
    localparam int RW   = tsse_pkg::ROOT_W;
    localparam int NSTG = 7 + SQS + 1 + DVS + 1 + 1;

    logic                 adv;
    logic [NSTG-1:0]      vld_reg, vld_next;

    // stage 1..7
    logic signed [63:0]   s1_p_reg [10];
    logic signed [31:0]   s1_x2_reg, s1_y2_reg;
    logic signed [63:0]   s2_v_reg [5];              // v0 v1 v2 w0 w1
    logic signed [31:0]   s2_x2_reg, s2_y2_reg;
    logic signed [63:0]   s3_v_reg [5];
    logic [63:0]          s3_m_reg;
    logic signed [31:0]   s3_x2_reg, s3_y2_reg;
    logic signed [63:0]   s4_v_reg [5];
    logic [5:0]           s4_p_reg;
    logic                 s4_degen_reg;
    logic signed [31:0]   s4_x2_reg, s4_y2_reg;
    logic signed [28:0]   s5_vs_reg [4];             // v0 v1 w0 w1 scaled
    logic signed [45:0]   s5_v2_reg;
    logic signed [31:0]   s5_x2_reg, s5_y2_reg;
    tsse_pkg::tsse_flags_t s5_f_reg;
    logic signed [63:0]   s6_e_reg [2];
    logic [56:0]          s6_sq_reg [4];
    logic signed [45:0]   s6_v2_reg;
    tsse_pkg::tsse_flags_t s6_f_reg;
    logic signed [63:0]   s7_ep_reg;
    logic [SQW-1:0]       s7_n_reg;
    tsse_pkg::tsse_flags_t s7_f_reg;

    // root and divide stages
    logic [SQW-1:0]       sq_n_reg [SQS+1];
    logic [SRW-1:0]       sq_r_reg [SQS+1];
    logic [63:0]          sq_a_reg [SQS+1];
    tsse_pkg::tsse_flags_t sq_f_reg [SQS+1];
    logic [RW-1:0]        dv_rem_reg [DVS+1];
    logic [RW-1:0]        dv_d_reg   [DVS+1];
    logic [DVS-1:0]       dv_lo_reg  [DVS+1];
    logic [DVS-1:0]       dv_q_reg   [DVS+1];
    tsse_pkg::tsse_flags_t dv_f_reg  [DVS+1];

    logic [31:0]          out_data_reg;
    logic [1:0]           out_user_reg;

    // combinational helpers
    logic [63:0]          mg [4];
    logic [63:0]          m_max;
    logic [5:0]           msb;
    logic [5:0]           sh;
    logic signed [63:0]   vsc [4];
    logic signed [91:0]   v2w, v2m;
    logic signed [63:0]   sqp [4];
    logic [63:0]          ap;
    logic [RW-1:0]        root;
    logic signed [31:0]   res;
    logic signed [32:0]   rx;
    logic [32:0]          resm;
    logic                 trunc;
    logic [DVS-1:0]       qf;
    tsse_pkg::tsse_flags_t ff;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    assign adv      = !vld_reg[NSTG-1] || m_tready;
    assign pop      = adv && !fifo_empty;
    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    assign vld_next = adv ? {vld_reg[NSTG-2:0], pop} : vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: products of E with both points
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_p_reg[0] <= $signed(emat[0]) * head.first_x;
            s1_p_reg[1] <= $signed(emat[1]) * head.first_y;
            s1_p_reg[2] <= $signed(emat[3]) * head.first_x;
            s1_p_reg[3] <= $signed(emat[4]) * head.first_y;
            s1_p_reg[4] <= $signed(emat[6]) * head.first_x;
            s1_p_reg[5] <= $signed(emat[7]) * head.first_y;
            s1_p_reg[6] <= $signed(emat[0]) * head.second_x;
            s1_p_reg[7] <= $signed(emat[3]) * head.second_y;
            s1_p_reg[8] <= $signed(emat[1]) * head.second_x;
            s1_p_reg[9] <= $signed(emat[4]) * head.second_y;
            s1_x2_reg   <= head.second_x;
            s1_y2_reg   <= head.second_y;
        end
    end

    // stage 2: E x1h and E' x2h in Q40
    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_v_reg[0] <= s1_p_reg[0] + s1_p_reg[1] + (64'($signed(emat[2])) <<< 16);
            s2_v_reg[1] <= s1_p_reg[2] + s1_p_reg[3] + (64'($signed(emat[5])) <<< 16);
            s2_v_reg[2] <= s1_p_reg[4] + s1_p_reg[5] + (64'($signed(emat[8])) <<< 16);
            s2_v_reg[3] <= s1_p_reg[6] + s1_p_reg[7] + (64'($signed(emat[6])) <<< 16);
            s2_v_reg[4] <= s1_p_reg[8] + s1_p_reg[9] + (64'($signed(emat[7])) <<< 16);
            s2_x2_reg   <= s1_x2_reg;
            s2_y2_reg   <= s1_y2_reg;
        end
    end

    // stage 3: largest magnitude of the denominator terms
    always_comb begin
        mg[0] = mag64(s2_v_reg[0]);
        mg[1] = mag64(s2_v_reg[1]);
        mg[2] = mag64(s2_v_reg[3]);
        mg[3] = mag64(s2_v_reg[4]);
        m_max = mg[0];
        for (int i = 1; i < 4; i++) begin
            if (mg[i] > m_max) begin
                m_max = mg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_v_reg  <= s2_v_reg;
            s3_m_reg  <= m_max;
            s3_x2_reg <= s2_x2_reg;
            s3_y2_reg <= s2_y2_reg;
        end
    end

    // stage 4: leading one position
    always_comb begin
        msb = '0;
        for (int i = 0; i < 64; i++) begin
            if (s3_m_reg[i]) begin
                msb = 6'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_v_reg     <= s3_v_reg;
            s4_p_reg     <= msb;
            s4_degen_reg <= s3_m_reg == '0;
            s4_x2_reg    <= s3_x2_reg;
            s4_y2_reg    <= s3_y2_reg;
        end
    end

    // stage 5: common power-of-two scaling
    always_comb begin
        if (s4_p_reg > 6'(tsse_pkg::LO_EXP)) begin
            sh = s4_p_reg - 6'(tsse_pkg::LO_EXP);
            vsc[0] = s4_v_reg[0] >>> sh;
            vsc[1] = s4_v_reg[1] >>> sh;
            vsc[2] = s4_v_reg[3] >>> sh;
            vsc[3] = s4_v_reg[4] >>> sh;
            v2w    = 92'(s4_v_reg[2]) >>> sh;
        end else begin
            sh = 6'(tsse_pkg::LO_EXP) - s4_p_reg;
            vsc[0] = s4_v_reg[0] <<< sh;
            vsc[1] = s4_v_reg[1] <<< sh;
            vsc[2] = s4_v_reg[3] <<< sh;
            vsc[3] = s4_v_reg[4] <<< sh;
            v2w    = 92'(s4_v_reg[2]) <<< sh;
        end
        v2m = v2w[91] ? -v2w : v2w;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                s5_vs_reg[i] <= vsc[i][28:0];
            end
            s5_v2_reg      <= v2w[45:0];
            s5_x2_reg      <= s4_x2_reg;
            s5_y2_reg      <= s4_y2_reg;
            s5_f_reg.degen <= s4_degen_reg;
            s5_f_reg.sat   <= |v2m[91:tsse_pkg::SAT_EXP];
            s5_f_reg.v2pos <= s4_v_reg[2] > 64'sd0;
            s5_f_reg.neg   <= 1'b0;
        end
    end

    // stage 6: numerator products and squares
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sqp[i] = s5_vs_reg[i] * s5_vs_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s6_e_reg[0] <= s5_x2_reg * s5_vs_reg[0];
            s6_e_reg[1] <= s5_y2_reg * s5_vs_reg[1];
            for (int i = 0; i < 4; i++) begin
                s6_sq_reg[i] <= sqp[i][56:0];
            end
            s6_v2_reg <= s5_v2_reg;
            s6_f_reg  <= s5_f_reg;
        end
    end

    // stage 7: scaled numerator and sum of squares
    always_ff @(posedge aclk) begin
        if (adv) begin
            s7_ep_reg <= s6_e_reg[0] + s6_e_reg[1] + (64'(s6_v2_reg) <<< 16);
            s7_n_reg  <= SQW'(s6_sq_reg[0]) + SQW'(s6_sq_reg[1]) +
                         SQW'(s6_sq_reg[2]) + SQW'(s6_sq_reg[3]);
            s7_f_reg  <= s6_f_reg;
        end
    end

    // root stage 0: load radicand and numerator magnitude
    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_n_reg[0]       <= s7_n_reg;
            sq_r_reg[0]       <= '0;
            sq_a_reg[0]       <= mag64(s7_ep_reg);
            sq_f_reg[0].degen <= s7_f_reg.degen;
            sq_f_reg[0].sat   <= s7_f_reg.sat;
            sq_f_reg[0].v2pos <= s7_f_reg.v2pos;
            sq_f_reg[0].neg   <= s7_ep_reg[63];
        end
    end

    // one root bit per stage
    for (genvar gi = 1; gi <= SQS; gi++) begin : g_sqrt
        localparam logic [SRW-1:0] ONE = 1;
        localparam logic [SRW-1:0] BIT = ONE << (2 * (SQS - gi));
        logic [SRW-1:0] trial;
        logic           take;

        assign trial = sq_r_reg[gi-1] + BIT;
        assign take  = {1'b0, sq_n_reg[gi-1]} >= trial;

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_n_reg[gi] <= take ? sq_n_reg[gi-1] - trial[SQW-1:0] : sq_n_reg[gi-1];
                sq_r_reg[gi] <= take ? (sq_r_reg[gi-1] >> 1) + BIT : sq_r_reg[gi-1] >> 1;
                sq_a_reg[gi] <= sq_a_reg[gi-1];
                sq_f_reg[gi] <= sq_f_reg[gi-1];
            end
        end
    end

    // divide stage 0: add half the root for rounding, split off the high bits
    assign root = sq_r_reg[SQS][RW-1:0];
    assign ap   = sq_a_reg[SQS] + 64'(root >> 1);

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_rem_reg[0] <= RW'(ap[63:DVS]);
            dv_d_reg[0]   <= root;
            dv_lo_reg[0]  <= ap[DVS-1:0];
            dv_q_reg[0]   <= '0;
            dv_f_reg[0]   <= sq_f_reg[SQS];
        end
    end

    // one quotient bit per stage
    for (genvar gj = 1; gj <= DVS; gj++) begin : g_div
        logic [RW:0] trial;
        logic        take;

        assign trial = {dv_rem_reg[gj-1], dv_lo_reg[gj-1][DVS-gj]};
        assign take  = trial >= {1'b0, dv_d_reg[gj-1]};

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_rem_reg[gj] <= take ? RW'(trial - {1'b0, dv_d_reg[gj-1]}) : trial[RW-1:0];
                dv_d_reg[gj]   <= dv_d_reg[gj-1];
                dv_lo_reg[gj]  <= dv_lo_reg[gj-1];
                dv_q_reg[gj]   <= {dv_q_reg[gj-1][DVS-2:0], take};
                dv_f_reg[gj]   <= dv_f_reg[gj-1];
            end
        end
    end

    // saturation, sign and truncation
    assign qf = dv_q_reg[DVS];
    assign ff = dv_f_reg[DVS];

    always_comb begin
        if (ff.degen) begin
            res = '0;
        end else if (ff.sat) begin
            res = ff.v2pos ? tsse_pkg::RES_MAX : tsse_pkg::RES_MIN;
        end else if (!ff.neg) begin
            res = (qf > DVS'(32'h7FFF_FFFF)) ? tsse_pkg::RES_MAX : $signed(qf[31:0]);
        end else begin
            res = (qf > DVS'(32'h8000_0000)) ? tsse_pkg::RES_MIN : -$signed(qf[31:0]);
        end
        rx    = 33'(res);
        resm  = rx[32] ? 33'(-rx) : 33'(rx);
        trunc = !ff.degen && !clamp_level[31] && (resm > {1'b0, clamp_level});
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg                       <= trunc ? clamp_level : res;
            out_user_reg[tsse_pkg::USER_TRUNC] <= trunc;
            out_user_reg[tsse_pkg::USER_DEGEN] <= ff.degen;
        end
    end

endmodule

[tb/tb_truncated_sampson_error.sv]
// tb_truncated_sampson_error: self-checking bench for the truncated sampson error block
// depends on tsse_pkg and the truncated_sampson_error rtl; predicts every residual in place
module tb_truncated_sampson_error;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] residual;
        logic               truncated;
        logic               degenerate;
    } score_t;

    class sampson_scoreboard;
        longint    pose_reg[tsse_pkg::NUM_REGS];
        score_t    pending_scores[$];
        int        mismatches;
        int        checked;
        int        degen_seen;
        int        trunc_seen;
        int        sat_seen;

        function void clear_regs();
            foreach (pose_reg[i]) pose_reg[i] = 0;
            pose_reg[tsse_pkg::REG_ROT_QW]      = 1073741823;
            pose_reg[tsse_pkg::REG_TRANS_Z]     = 1073741823;
            pose_reg[tsse_pkg::REG_CLAMP_LEVEL] = -65536;
        endfunction

        function void write_reg(tsse_pkg::tsse_reg_t idx, logic [31:0] val);
            logic signed [30:0] p;
            logic signed [31:0] c;
            p = val[30:0];
            c = val;
            if (idx == tsse_pkg::REG_CLAMP_LEVEL) pose_reg[idx] = c;
            else pose_reg[idx] = p;
        endfunction

        static function longint round_shift(longint v, int n);
            return (v + (longint'(1) <<< (n - 1))) >>> n;
        endfunction

        // rounded (p1 - p2) / 2^n without forming the difference
        static function longint round_diff(longint p1, longint p2, int n);
            longint h1, h2, l1, l2;
            h1 = p1 >>> n;
            h2 = p2 >>> n;
            l1 = p1 - (h1 <<< n);
            l2 = p2 - (h2 <<< n);
            return h1 - h2 + ((l1 - l2 + (longint'(1) <<< (n - 1))) >>> n);
        endfunction

        static function longint unsigned magnitude(longint v);
            return v < 0 ? -v : v;
        endfunction

        static function longint unsigned root_floor(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        static function longint clip_coord(logic [31:0] raw);
            longint v, lim;
            v = longint'(signed'(raw));
            if (tsse_pkg::COORD_WIDTH < 32) begin
                lim = longint'(1) <<< (tsse_pkg::COORD_WIDTH - 1);
                if (v >= lim) v = lim - 1;
                if (v < -lim) v = -lim;
            end
            return v;
        endfunction

        function score_t sampson_score(tsse_pkg::tsse_item_t it);
            score_t s;
            longint qx, qy, qz, qw, tx, ty, tz, thr;
            longint x1, y1, x2, y2, v0, v1, v2, w0, w1, res, f, ep;
            longint rm[3][3];
            longint em[3][3];
            longint unsigned m, n, r, q;
            bit sat;
            int k;
            qx = pose_reg[0]; qy = pose_reg[1]; qz = pose_reg[2]; qw = pose_reg[3];
            tx = pose_reg[4]; ty = pose_reg[5]; tz = pose_reg[6]; thr = pose_reg[7];
            x1 = clip_coord(it.first_x);
            y1 = clip_coord(it.first_y);
            x2 = clip_coord(it.second_x);
            y2 = clip_coord(it.second_y);
            rm[0][0] = (longint'(1) <<< 30) - round_shift(qy * qy + qz * qz, 29);
            rm[0][1] = round_shift(qx * qy - qz * qw, 29);
            rm[0][2] = round_shift(qx * qz + qy * qw, 29);
            rm[1][0] = round_shift(qx * qy + qz * qw, 29);
            rm[1][1] = (longint'(1) <<< 30) - round_shift(qx * qx + qz * qz, 29);
            rm[1][2] = round_shift(qy * qz - qx * qw, 29);
            rm[2][0] = round_shift(qx * qz - qy * qw, 29);
            rm[2][1] = round_shift(qy * qz + qx * qw, 29);
            rm[2][2] = (longint'(1) <<< 30) - round_shift(qx * qx + qy * qy, 29);
            for (int j = 0; j < 3; j++) begin
                em[0][j] = round_diff(ty * rm[2][j], tz * rm[1][j], 36);
                em[1][j] = round_diff(tz * rm[0][j], tx * rm[2][j], 36);
                em[2][j] = round_diff(tx * rm[1][j], ty * rm[0][j], 36);
            end
            v0 = em[0][0] * x1 + em[0][1] * y1 + (em[0][2] <<< 16);
            v1 = em[1][0] * x1 + em[1][1] * y1 + (em[1][2] <<< 16);
            v2 = em[2][0] * x1 + em[2][1] * y1 + (em[2][2] <<< 16);
            w0 = em[0][0] * x2 + em[1][0] * y2 + (em[2][0] <<< 16);
            w1 = em[0][1] * x2 + em[1][1] * y2 + (em[2][1] <<< 16);
            m = magnitude(v0);
            if (magnitude(v1) > m) m = magnitude(v1);
            if (magnitude(w0) > m) m = magnitude(w0);
            if (magnitude(w1) > m) m = magnitude(w1);
            s.residual = 0;
            s.truncated = 0;
            s.degenerate = 0;
            sat = 0;
            res = 0;
            if (m == 0) begin
                s.degenerate = 1;
                return s;
            end
            if (m >= (64'd1 << 28)) begin
                k = 0;
                while ((m >> k) >= (64'd1 << 28)) k++;
                v0 = v0 >>> k; v1 = v1 >>> k; v2 = v2 >>> k;
                w0 = w0 >>> k; w1 = w1 >>> k;
                if (magnitude(v2) >= (64'd1 << 45)) sat = 1;
            end else begin
                k = 0;
                while ((m << k) < (64'd1 << 27)) k++;
                f = longint'(1) <<< k;
                if (magnitude(v2) >= (64'd1 << (45 - k))) sat = 1;
                else v2 = v2 * f;
                v0 = v0 * f; v1 = v1 * f; w0 = w0 * f; w1 = w1 * f;
            end
            if (sat) begin
                sat_seen++;
                res = v2 > 0 ? 64'sd2147483647 : -64'sd2147483648;
            end else begin
                ep = x2 * v0 + y2 * v1 + (v2 <<< 16);
                n = v0 * v0 + v1 * v1 + w0 * w0 + w1 * w1;
                r = root_floor(n);
                q = (magnitude(ep) + (r >> 1)) / r;
                if (ep >= 0) res = q > 64'd2147483647 ? 64'sd2147483647 : longint'(q);
                else res = q > (64'd1 << 31) ? -64'sd2147483648 : -longint'(q);
            end
            if (thr >= 0 && longint'(magnitude(res)) > thr) begin
                res = thr;
                s.truncated = 1;
            end
            s.residual = res[31:0];
            return s;
        endfunction

        function void note_input(tsse_pkg::tsse_item_t it);
            pending_scores.push_back(sampson_score(it));
        endfunction

        function void check_result(logic [31:0] residual, logic [1:0] flags);
            score_t e;
            if (pending_scores.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction residual=%h flags=%b",
                             residual, flags);
                return;
            end
            e = pending_scores.pop_front();
            checked++;
            if (e.degenerate) degen_seen++;
            if (e.truncated) trunc_seen++;
            if (residual !== e.residual || flags[tsse_pkg::USER_TRUNC] !== e.truncated ||
                flags[tsse_pkg::USER_DEGEN] !== e.degenerate) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch #%0d: residual exp %h got %h,",
                             checked, e.residual, residual,
                             " trunc exp %b got %b, degen exp %b got %b",
                             e.truncated, flags[tsse_pkg::USER_TRUNC],
                             e.degenerate, flags[tsse_pkg::USER_DEGEN]);
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;    // first_x, first_y, second_x, second_y
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [31:0]  m_tdata;         // residual
    logic [1:0]   m_tuser;         // truncated, degenerate
    logic         psel = 0;
    logic         penable = 0;
    logic         pwrite = 0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    sampson_scoreboard scores = new();
    int           burst_left = 0;
    int           items_sent = 0;
    bit           stall_mode = 0;

    truncated_sampson_error DUT (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            scores.note_input(tsse_pkg::tsse_item_t'({s_tdata[31:0],
                s_tdata[63:32], s_tdata[95:64], s_tdata[127:96]}));
        if (aresetn && m_tvalid && m_tready) scores.check_result(m_tdata, m_tuser);
    end

    // receiver: long ready stretches alternate with phases of random stalls
    always @(posedge aclk) begin
        if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
        if (stall_mode) m_tready <= ($urandom_range(0, 3) != 0) && ($urandom_range(0, 9) != 0);
        else m_tready <= 1'b1;
    end

    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", scores.pending_scores.size());
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic reg_write(tsse_pkg::tsse_reg_t idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= 5'(4 * int'(idx));
        pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        scores.write_reg(idx, val);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic set_pose(logic [31:0] qx, logic [31:0] qy, logic [31:0] qz,
                            logic [31:0] qw, logic [31:0] tx, logic [31:0] ty,
                            logic [31:0] tz, logic [31:0] clamp);
        reg_write(tsse_pkg::REG_ROT_QX, qx);
        reg_write(tsse_pkg::REG_ROT_QY, qy);
        reg_write(tsse_pkg::REG_ROT_QZ, qz);
        reg_write(tsse_pkg::REG_ROT_QW, qw);
        reg_write(tsse_pkg::REG_TRANS_X, tx);
        reg_write(tsse_pkg::REG_TRANS_Y, ty);
        reg_write(tsse_pkg::REG_TRANS_Z, tz);
        reg_write(tsse_pkg::REG_CLAMP_LEVEL, clamp);
    endtask

    task automatic send_point(logic [31:0] x1, logic [31:0] y1, logic [31:0] x2,
                              logic [31:0] y2);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        s_tvalid <= 1;
        s_tdata <= {y2, x2, y1, x1};
        @(posedge aclk iff s_tready);
        burst_left--;
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        burst_left = 0;
        while (scores.pending_scores.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 14) return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
        if (sel < 17) return 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
        return $urandom;
    endfunction

    function automatic logic [31:0] rand_pose_comp(bit wide);
        if (wide) return $urandom;
        return 32'($urandom_range(0, 1 << 31)) - 32'(1 << 30);
    endfunction

    task automatic extreme_points();
        send_point(32'h0, 32'h0, 32'h0, 32'h0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h0001_0000, 32'h0, 32'hFFFF_0000, 32'h0001_0000);
        send_point(32'h0000_8000, 32'hFFFF_8000, 32'h0000_8000, 32'h0000_4000);
    endtask

    initial begin
        scores.clear_regs();
        repeat (12) @(posedge aclk);
        aresetn <= 1;

        // default pose, then the pose register extremes and a zero translation
        extreme_points();
        drain();
        set_pose(32'hC000_0000, 32'hC000_0000, 32'hC000_0000, 32'hC000_0000,
                 32'hC000_0000, 32'hC000_0000, 32'hC000_0000, 32'h0);
        extreme_points();
        drain();
        set_pose(32'h3FFF_FFFF, 32'h3FFF_FFFF, 32'h3FFF_FFFF, 32'h3FFF_FFFF,
                 32'h3FFF_FFFF, 32'h3FFF_FFFF, 32'h3FFF_FFFF, 32'h7FFF_FFFF);
        extreme_points();
        drain();
        set_pose(32'h1234_5678, 32'h0, 32'h0, 32'h3FFF_FFFF,
                 32'h0, 32'h0, 32'h0, 32'h8000_0000);
        send_point(32'h0001_0000, 32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(rand_coord(), rand_coord(), rand_coord(), rand_coord());
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            logic [31:0] clamp;
            bit wide;
            wide = (ph == 7);
            case (ph % 4)
                0: clamp = 32'($urandom_range(0, 1 << 17));
                1: clamp = 32'h8000_0000 | $urandom;
                2: clamp = 32'h0;
                default: clamp = $urandom;
            endcase
            set_pose(rand_pose_comp(wide), rand_pose_comp(wide), rand_pose_comp(wide),
                     rand_pose_comp(wide), rand_pose_comp(wide), rand_pose_comp(wide),
                     rand_pose_comp(wide), clamp);
            repeat (55) send_point(rand_coord(), rand_coord(), rand_coord(), rand_coord());
            drain();
        end

        $display("sent %0d correspondences, checked %0d results over 12 poses", items_sent,
                 scores.checked);
        $display("degenerate %0d, truncated %0d, saturated %0d, mismatches %0d",
                 scores.degen_seen, scores.trunc_seen, scores.sat_seen, scores.mismatches);
        if (scores.mismatches == 0 && scores.pending_scores.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
